@@ sv/mfpc_pkg.sv @@
// shared types and constants for the multichannel flow pulse counter
// used by mfpc_div, mfpc_counts and multichannel_flow_pulse_counter
`default_nettype none

package mfpc_pkg;

	localparam int LEVEL_BITS = 8;   // sensor pins in a sample transaction
	localparam int CFG_BITS   = 8;   // width of every configuration register
	localparam int PPML_BITS  = 8;   // pulses-per-millilitre register width
	localparam int ML_BITS    = 16;  // millilitres result width
	localparam int CH_BITS    = 3;   // channel field width

	localparam logic [ML_BITS-1:0]   ML_MAX     = 16'hFFFF;
	localparam logic [PPML_BITS-1:0] PPML_RESET = 8'd18;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic REG_ENABLE_MASK = 1'b0;
	localparam logic REG_PPML        = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// control from the sequencer to the count bank
	typedef struct packed {
		logic clear;
		logic sample;
		logic write;
	} cnt_ctrl_t;

endpackage

`default_nettype wire

@@ sv/mfpc_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// divides a count by the 8-bit pulses-per-millilitre value; uses mfpc_pkg
`default_nettype none

module mfpc_div #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [COUNT_BITS-1:0]            dividend,
	input  wire logic [mfpc_pkg::PPML_BITS-1:0]   divisor,
	output logic                                  done,
	output logic [COUNT_BITS-1:0]                 quotient,
	output logic [mfpc_pkg::PPML_BITS-1:0]        remainder
);

	localparam int STEP_W = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;

	logic                              busy_q;
	logic                              done_q;
	logic [STEP_W-1:0]                 step_q;
	logic [COUNT_BITS-1:0]             quo_q;
	logic [mfpc_pkg::PPML_BITS-1:0]    rem_q;
	logic [mfpc_pkg::PPML_BITS:0]      trial;
	logic [mfpc_pkg::PPML_BITS:0]      diff;
	logic                              fits;

	// shift the next dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[COUNT_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(COUNT_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[COUNT_BITS-2:0], fits};
			rem_q <= fits ? diff[mfpc_pkg::PPML_BITS-1:0] : trial[mfpc_pkg::PPML_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ sv/mfpc_counts.sv @@
// per-channel pulse counters with falling-edge detection on the sampled pins
// one read port and one write port; uses mfpc_pkg
`default_nettype none

module mfpc_counts #(
	parameter int CHANNELS   = 8,
	parameter int COUNT_BITS = 16,
	parameter int CH_IDX_W   = 3
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mfpc_pkg::cnt_ctrl_t               ctrl,
	input  wire logic [mfpc_pkg::LEVEL_BITS-1:0]   pin_levels,
	input  wire logic [mfpc_pkg::CFG_BITS-1:0]     enable_mask,
	input  wire logic [CH_IDX_W-1:0]               wr_idx,
	input  wire logic [COUNT_BITS-1:0]             wr_data,
	input  wire logic [CH_IDX_W-1:0]               rd_idx,
	output logic [COUNT_BITS-1:0]                  rd_data
);

	logic [COUNT_BITS-1:0]             counts_q [CHANNELS];
	logic [mfpc_pkg::LEVEL_BITS-1:0]   last_levels_q;
	logic [31:0]                       fall_wide;

	// channels above the pin count have no pin and never count
	assign fall_wide = 32'(last_levels_q & ~pin_levels & enable_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_levels_q <= '0;
		end else if (ctrl.sample) begin
			last_levels_q <= pin_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int i = 0; i < CHANNELS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (ctrl.write) begin
			counts_q[wr_idx] <= wr_data;
		end else if (ctrl.sample) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (fall_wide[i]) begin
					counts_q[i] <= counts_q[i] + 1'b1;
				end
			end
		end
	end

	assign rd_data = counts_q[rd_idx];

endmodule

`default_nettype wire

@@ sv/multichannel_flow_pulse_counter.sv @@
// Flow pulse counter for up to CHANNELS sensor channels (pins on channels 0 to 7).
// Input channel (in_valid/in_stall): opcode selects a pin sample or a millilitre read.
// A sample transaction is taken while idle and leaves the block idle: each enabled channel whose pin fell
// since the previous sample counts one pulse; no result is returned.
// A read transaction divides the channel's count by the pulses-per-millilitre value
// in a shared one-bit-per-cycle divider, drains the whole millilitres from the count
// and keeps the remainder. The read passes through the divide, drain and done states
// (with a multiply state before drain when a wide count saturates the result), and
// out_valid rises once the result is loaded. in_stall is high from acceptance
// until the result has been placed in the output register, so the next transaction
// is taken only once the read has finished.
// A read of a channel past CHANNELS or with a zero divisor skips the divider and returns 0.
// Output channel (out_valid/out_stall): millilitres is held in a register while
// out_stall is high; a new sample may be accepted meanwhile, and a finished read
// waits in its last state until the register is free.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 writes enable_mask and
// clears every count, index 1 writes pulses per millilitre. Write only while idle.
// Reset: counts and pin history zero, enable_mask 0, 18 pulses per millilitre, no result.
`default_nettype none

module multichannel_flow_pulse_counter #(
	parameter int CHANNELS   = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [mfpc_pkg::LEVEL_BITS-1:0]   pin_levels,
	input  wire logic [mfpc_pkg::CH_BITS-1:0]      channel,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mfpc_pkg::ML_BITS-1:0]           millilitres,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic                              cfg_index,
	input  wire logic [mfpc_pkg::CFG_BITS-1:0]     cfg_data
);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W   = mfpc_pkg::ML_BITS + mfpc_pkg::PPML_BITS;

	mfpc_pkg::state_t                   state_q, state_d;
	mfpc_pkg::cnt_ctrl_t                cnt_ctrl;

	logic [mfpc_pkg::CFG_BITS-1:0]      enable_mask_q;
	logic [mfpc_pkg::PPML_BITS-1:0]     ppml_q;
	logic [CH_IDX_W-1:0]                rd_idx;
	logic [CH_IDX_W-1:0]                ch_idx_q;
	logic [COUNT_BITS-1:0]              rd_data;
	logic [COUNT_BITS-1:0]              cnt_q;
	logic [COUNT_BITS-1:0]              new_count_q;
	logic [mfpc_pkg::ML_BITS-1:0]       ml_q;
	logic [PROD_W-1:0]                  prod_s1;
	logic                               out_valid_q;
	logic [mfpc_pkg::ML_BITS-1:0]       millilitres_q;

	logic                               in_fire;
	logic                               cfg_fire;
	logic                               read_ok;
	logic                               div_start;
	logic                               div_done;
	logic [COUNT_BITS-1:0]              div_quo;
	logic [mfpc_pkg::PPML_BITS-1:0]     div_rem;
	logic [31:0]                        quo_wide;
	logic                               quo_sat;
	logic                               out_load;
	logic                               out_free;

	assign in_stall  = (state_q != mfpc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && !in_stall;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// channel numbers past the last counter read as zero and change nothing
	assign rd_idx  = CH_IDX_W'(channel);
	assign read_ok = ({29'd0, channel} < 32'(CHANNELS)) && (ppml_q != '0);

	assign quo_wide = 32'(div_quo);
	assign quo_sat  = |quo_wide[31:mfpc_pkg::ML_BITS];
	assign out_free = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= '0;
			ppml_q        <= mfpc_pkg::PPML_RESET;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				mfpc_pkg::REG_ENABLE_MASK: enable_mask_q <= cfg_data;
				mfpc_pkg::REG_PPML:        ppml_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfpc_pkg::ST_IDLE: begin
				if (in_fire && opcode == mfpc_pkg::OP_READ) begin
					state_d = read_ok ? mfpc_pkg::ST_DIV : mfpc_pkg::ST_DONE;
				end
			end
			mfpc_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = quo_sat ? mfpc_pkg::ST_MUL : mfpc_pkg::ST_DRAIN;
				end
			end
			mfpc_pkg::ST_MUL:   state_d = mfpc_pkg::ST_DRAIN;
			mfpc_pkg::ST_DRAIN: state_d = mfpc_pkg::ST_DONE;
			mfpc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = mfpc_pkg::ST_IDLE;
				end
			end
			default: state_d = mfpc_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		div_start      = 1'b0;
		out_load       = 1'b0;
		cnt_ctrl       = '0;
		cnt_ctrl.clear = cfg_fire && (cfg_index == mfpc_pkg::REG_ENABLE_MASK);
		unique case (state_q)
			mfpc_pkg::ST_IDLE: begin
				cnt_ctrl.sample = in_fire && (opcode == mfpc_pkg::OP_SAMPLE);
				div_start       = in_fire && (opcode == mfpc_pkg::OP_READ) && read_ok;
			end
			mfpc_pkg::ST_DRAIN: cnt_ctrl.write = 1'b1;
			mfpc_pkg::ST_DONE:  out_load       = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// read datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_idx_q <= rd_idx;
			cnt_q    <= rd_data;
			ml_q     <= '0;
		end
		if (state_q == mfpc_pkg::ST_DIV && div_done) begin
			ml_q        <= quo_wide[mfpc_pkg::ML_BITS-1:0];
			new_count_q <= COUNT_BITS'(div_rem);
			prod_s1     <= mfpc_pkg::ML_MAX * ppml_q;
		end
		// saturated quotient: drain only the largest result's worth of pulses
		if (state_q == mfpc_pkg::ST_MUL) begin
			ml_q        <= mfpc_pkg::ML_MAX;
			new_count_q <= COUNT_BITS'(32'(cnt_q) - 32'(prod_s1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			millilitres_q <= ml_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign millilitres = millilitres_q;

	mfpc_counts #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS),
		.CH_IDX_W   (CH_IDX_W)
	) u_counts (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (cnt_ctrl),
		.pin_levels  (pin_levels),
		.enable_mask (enable_mask_q),
		.wr_idx      (ch_idx_q),
		.wr_data     (new_count_q),
		.rd_idx      (rd_idx),
		.rd_data     (rd_data)
	);

	mfpc_div #(
		.COUNT_BITS (COUNT_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rd_data),
		.divisor   (ppml_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

`ifndef ASSERT_OFF
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == mfpc_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_drain_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mfpc_pkg::ST_DRAIN |->
			$past(state_q) == mfpc_pkg::ST_DIV || $past(state_q) == mfpc_pkg::ST_MUL)
		else $error("count drained without a division");

	a_load_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && !in_stall)
		else $error("result load did not release the input side");
`endif

endmodule

`default_nettype wire
